>>> rtl/shortest_nonce_pow_search_core_macros.svh
// Assertion macros shared by the nonce search RTL.
// Depends on nothing; included by files that carry assertions.
`ifndef SHORTEST_NONCE_POW_SEARCH_CORE_MACROS_SVH
`define SHORTEST_NONCE_POW_SEARCH_CORE_MACROS_SVH

// implication checked every clock outside reset
`define SNP_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication checked every clock outside reset
`define SNP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/snps_pkg.sv
// Package for the nonce search core: payload types, SHA-256 constants and helpers.
// No dependencies.
package snps_pkg;

  localparam int MaxNonceBytesDef = 4;
  localparam logic [7:0] ByteMask = 8'd255;
  localparam int ByteSpan = 256;

  typedef struct packed {
    logic [63:0] digest_word_3;
    logic [63:0] digest_word_2;
    logic [63:0] digest_word_1;
    logic [63:0] digest_word_0;
  } in_beat_t;

  typedef struct packed {
    logic        solved;
    logic [2:0]  nonce_length;
    logic [31:0] nonce_value;
  } out_beat_t;

  localparam logic [31:0] RoundK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [255:0] InitH = {
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

  // byte-swap a 32-bit word
  function automatic logic [31:0] bswap(input logic [31:0] x);
    bswap = {x[7:0], x[15:8], x[23:16], x[31:24]};
  endfunction

  // compact difficulty to 256-bit target, byte i at bits 8i+7:8i
  function automatic logic [255:0] build_target(input logic [31:0] bits);
    logic [255:0] t;
    logic [22:0]  mant;
    int           pos;
    t = '0;
    mant = bits[22:0];
    for (int k = 0; k < 3; k++) begin
      pos = int'(bits[31:24]) - 3 + k;
      if (pos >= 0 && pos < 32) begin
        t[pos*8 +: 8] = 8'({1'b0, mant} >> (8 * k)) & ByteMask;
      end
    end
    build_target = t;
  endfunction

endpackage

>>> rtl/snps_sha_unit.sv
// Iterative SHA-256 compression: one round per cycle over a 16-word sliding schedule.
// Depends on snps_pkg.
`include "shortest_nonce_pow_search_core_macros.svh"
module snps_sha_unit (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [511:0] block,   // word 0 in bits 511:480
  output logic         done,
  output logic [255:0] digest   // H0 in bits 255:224
);

  logic [6:0]   rnd_r, rnd_nxt;
  logic         busy_r, busy_nxt, done_r, done_nxt;
  logic [31:0]  w_r [16];
  logic [31:0]  w_nxt [16];
  logic [255:0] st_r, st_nxt, dig_r, dig_nxt;
  logic [31:0]  a, b, c, d, e, f, g, h, wt, t1, t2, s0, s1, wn;

  always_comb begin
    {a, b, c, d, e, f, g, h} = st_r;
    s0 = snps_pkg::rotr(w_r[1], 7) ^ snps_pkg::rotr(w_r[1], 18) ^ (w_r[1] >> 3);
    s1 = snps_pkg::rotr(w_r[14], 17) ^ snps_pkg::rotr(w_r[14], 19) ^ (w_r[14] >> 10);
    wn = w_r[0] + s0 + w_r[9] + s1;
    wt = w_r[0];
    t1 = h + (snps_pkg::rotr(e, 6) ^ snps_pkg::rotr(e, 11) ^ snps_pkg::rotr(e, 25))
         + ((e & f) ^ (~e & g)) + snps_pkg::RoundK[rnd_r[5:0]] + wt;
    t2 = (snps_pkg::rotr(a, 2) ^ snps_pkg::rotr(a, 13) ^ snps_pkg::rotr(a, 22))
         + ((a & b) ^ (a & c) ^ (b & c));
    rnd_nxt = rnd_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    st_nxt = st_r;
    dig_nxt = dig_r;
    w_nxt = w_r;
    if (start) begin
      busy_nxt = 1'b1;
      rnd_nxt = '0;
      st_nxt = snps_pkg::InitH;
      for (int i = 0; i < 16; i++) w_nxt[i] = block[511 - 32*i -: 32];
    end else if (busy_r) begin
      st_nxt = {t1 + t2, a, b, c, d + t1, e, f, g};
      // slide the schedule window; new word enters at the top
      for (int i = 0; i < 15; i++) w_nxt[i] = w_r[i + 1];
      w_nxt[15] = wn;
      rnd_nxt = rnd_r + 7'd1;
      if (rnd_r == 7'd63) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
        for (int i = 0; i < 8; i++) begin
          dig_nxt[255 - 32*i -: 32] = snps_pkg::InitH[255 - 32*i -: 32]
                                      + st_nxt[255 - 32*i -: 32];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      rnd_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      rnd_r <= rnd_nxt;
    end
    st_r <= st_nxt;
    dig_r <= dig_nxt;
    w_r <= w_nxt;
  end

  assign done = done_r;
  assign digest = dig_r;

  `SNP_ASSERT_NEXT(a_sha_done_ends_busy, clk, rst_n, busy_r && rnd_r == 7'd63, done_r && !busy_r, "round 63 must finish")
  `SNP_ASSERT_IMPL(a_sha_round_range, clk, rst_n, busy_r, rnd_r < 7'd64, "round count out of range")
  `SNP_ASSERT_IMPL(a_sha_no_done_busy, clk, rst_n, done_r, !busy_r, "done while busy")

endmodule

>>> rtl/shortest_nonce_pow_search_core.sv
// Channel | dir | handshake          | payload
// in      | in  | in_valid/in_stall  | snps_pkg::in_beat_t (32-byte first-stage digest)
// out     | out | out_valid/out_stall| snps_pkg::out_beat_t (solved, length, nonce)
// cfg     | in  | cfg_we             | cfg_wdata: compact difficulty
// Each nonce attempt takes two 64-round passes of the shared SHA unit plus one
// check state. A beat tries up to 2^8+2^16+2^24+2^32 attempts before its result
// beat. Synchronous active-low reset; no clearing pass. The input stalls from
// accept until the result beat leaves; out_stall holds it.
// Depends on snps_pkg, snps_sha_unit and the assertion macro header.
`include "shortest_nonce_pow_search_core_macros.svh"
module shortest_nonce_pow_search_core #(
  parameter int MAX_NONCE_BYTES = snps_pkg::MaxNonceBytesDef
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  snps_pkg::in_beat_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output snps_pkg::out_beat_t out_data,
  input  logic                cfg_we,
  input  logic [31:0]         cfg_wdata
);

  typedef enum logic [2:0] {S_IDLE, S_H1, S_W1, S_H2, S_W2, S_CHK, S_OUT} state_t;

  localparam int NW = 8 * MAX_NONCE_BYTES;

  state_t              state_r, state_nxt;
  logic [31:0]         diff_r;
  logic [255:0]        target_r, target_nxt;
  logic [255:0]        held_r, held_nxt;
  logic [NW-1:0]       count_r, count_nxt;
  logic [3:0]          len_r, len_nxt;
  logic [255:0]        hash_r, hash_nxt;
  snps_pkg::out_beat_t res_r, res_nxt;
  logic                start;
  logic [511:0]        blk;
  logic                sha_done;
  logic [255:0]        sha_dig;
  logic [255:0]        hash_le;
  logic [NW-1:0]       last;
  logic [511:0]        msg_le;

  // message bytes little-endian, byte j at bits 8j+7:8j, then pad and length
  always_comb begin
    msg_le = '0;
    blk = '0;
    if (state_r == S_H1) begin
      msg_le[255:0] = held_r;
      for (int i = 0; i < MAX_NONCE_BYTES; i++) begin
        if (i < int'(len_r)) msg_le[256 + 8*i +: 8] = count_r[8*i +: 8];
        if (i == int'(len_r)) msg_le[256 + 8*i +: 8] = 8'h80;
      end
      if (MAX_NONCE_BYTES == int'(len_r)) msg_le[256 + 8*MAX_NONCE_BYTES +: 8] = 8'h80;
      for (int i = 0; i < 16; i++) blk[511 - 32*i -: 32] = snps_pkg::bswap(msg_le[32*i +: 32]);
      blk[15:0] = 16'((32 + int'(len_r)) * 8);
    end else begin
      blk[511:256] = hash_r;
      blk[255:224] = 32'h80000000;
      blk[15:0] = 16'd256;
    end
  end

  assign start = (state_r == S_H1) || (state_r == S_H2);

  snps_sha_unit u_sha (
    .clk(clk), .rst_n(rst_n), .start(start), .block(blk),
    .done(sha_done), .digest(sha_dig)
  );

  // hash bytes in big-endian word order; byte i of the hash lands at bits 8i+7:8i
  always_comb begin
    for (int i = 0; i < 8; i++) hash_le[32*i +: 32] = snps_pkg::bswap(hash_r[255 - 32*i -: 32]);
    last = '0;
    for (int i = 0; i < MAX_NONCE_BYTES; i++) begin
      if (i < int'(len_r)) last[8*i +: 8] = snps_pkg::ByteMask;
    end
  end

  always_comb begin
    state_nxt = state_r;
    target_nxt = target_r;
    held_nxt = held_r;
    count_nxt = count_r;
    len_nxt = len_r;
    hash_nxt = hash_r;
    res_nxt = res_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          held_nxt = in_data;
          target_nxt = snps_pkg::build_target(diff_r);
          count_nxt = '0;
          len_nxt = 4'd1;
          state_nxt = S_H1;
        end
      end
      S_H1: state_nxt = S_W1;
      S_W1: begin
        if (sha_done) begin
          hash_nxt = sha_dig;
          state_nxt = S_H2;
        end
      end
      S_H2: state_nxt = S_W2;
      S_W2: begin
        if (sha_done) begin
          hash_nxt = sha_dig;
          state_nxt = S_CHK;
        end
      end
      S_CHK: begin
        state_nxt = S_H1;
        if (hash_le <= target_r) begin
          res_nxt.solved = 1'b1;
          res_nxt.nonce_length = len_r[2:0];
          res_nxt.nonce_value = 32'(count_r);
          state_nxt = S_OUT;
        end else if (count_r == last) begin
          count_nxt = '0;
          len_nxt = len_r + 4'd1;
          if (int'(len_r) >= MAX_NONCE_BYTES) begin
            res_nxt = '0;
            state_nxt = S_OUT;
          end
        end else begin
          count_nxt = count_r + NW'(1);
        end
      end
      S_OUT: if (!out_stall) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      diff_r <= '0;
      target_r <= '0;
      count_r <= '0;
      len_r <= 4'd1;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) diff_r <= cfg_wdata;
      target_r <= target_nxt;
      count_r <= count_nxt;
      len_r <= len_nxt;
    end
    held_r <= held_nxt;
    hash_r <= hash_nxt;
    res_r <= res_nxt;
  end

  assign in_stall = (state_r != S_IDLE);
  assign out_valid = (state_r == S_OUT);
  assign out_data = res_r;

  `SNP_ASSERT_IMPL(a_one_job, clk, rst_n, out_valid, in_stall, "input open while result pending")
  `SNP_ASSERT_IMPL(a_len_range, clk, rst_n, state_r == S_CHK, len_r >= 4'd1, "nonce length zero")
  `SNP_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_data), "result dropped under stall")

endmodule
